### rtl/anchored_axis_remapper_macros.svh
// Assertion helpers shared by the remapper modules.
`ifndef ANCHORED_AXIS_REMAPPER_MACROS_SVH
`define ANCHORED_AXIS_REMAPPER_MACROS_SVH

// Check a property at every rising edge outside reset.
`define AAR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("anchored_axis_remapper: assertion failed");

// Check that a signal does not change in the cycle after a condition.
`define AAR_ASSERT_STABLE(label, clk, rst, cond, sig) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("anchored_axis_remapper: signal moved while held");

`endif

### rtl/aar_pkg.sv
`timescale 1ns / 1ps

package aar_pkg;

  localparam int COORD_BITS     = 16;
  localparam int PROD_BITS      = 2 * COORD_BITS;
  localparam int CFG_INDEX_BITS = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_MIN         = CFG_INDEX_BITS'(0),
    REG_SOURCE_MAX         = CFG_INDEX_BITS'(1),
    REG_TARGET_MIN         = CFG_INDEX_BITS'(2),
    REG_TARGET_MAX         = CFG_INDEX_BITS'(3),
    REG_SOURCE_ANCHOR_LOW  = CFG_INDEX_BITS'(4),
    REG_SOURCE_ANCHOR_HIGH = CFG_INDEX_BITS'(5),
    REG_TARGET_ANCHOR_LOW  = CFG_INDEX_BITS'(6),
    REG_TARGET_ANCHOR_HIGH = CFG_INDEX_BITS'(7)
  } cfg_reg_t;

  typedef struct packed {
    coord_t source_min;
    coord_t source_max;
    coord_t target_min;
    coord_t target_max;
    coord_t source_anchor_low;
    coord_t source_anchor_high;
    coord_t target_anchor_low;
    coord_t target_anchor_high;
  } cfg_t;

  // One classified coordinate waiting for the arithmetic back end.
  typedef struct packed {
    logic   early;   // result known without dividing
    coord_t eval;    // that result
    coord_t off;     // s - lo
    coord_t span;    // hi - lo
    coord_t tspan;   // |thi - tlo|
    coord_t tlo;
    logic   dir;     // target falls across the segment
  } work_t;

endpackage

### rtl/aar_ifs.sv
`timescale 1ns / 1ps

interface aar_raw_if import aar_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t raw_coord;
  modport source (output valid, raw_coord, input ready);
  modport sink (input valid, raw_coord, output ready);
endinterface

interface aar_mapped_if import aar_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t mapped_coord;
  modport source (output valid, mapped_coord, input ready);
  modport sink (input valid, mapped_coord, output ready);
endinterface

interface aar_cfg_if import aar_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  coord_t                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/aar_cfg.sv
`timescale 1ns / 1ps

module aar_cfg import aar_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  aar_cfg_if.sink      cfg,
  output cfg_t         regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.source_min         <= '0;
      regs.source_max         <= '1;
      regs.target_min         <= '0;
      regs.target_max         <= '1;
      regs.source_anchor_low  <= '0;
      regs.source_anchor_high <= '0;
      regs.target_anchor_low  <= '0;
      regs.target_anchor_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SOURCE_MIN:         regs.source_min         <= cfg.data;
        REG_SOURCE_MAX:         regs.source_max         <= cfg.data;
        REG_TARGET_MIN:         regs.target_min         <= cfg.data;
        REG_TARGET_MAX:         regs.target_max         <= cfg.data;
        REG_SOURCE_ANCHOR_LOW:  regs.source_anchor_low  <= cfg.data;
        REG_SOURCE_ANCHOR_HIGH: regs.source_anchor_high <= cfg.data;
        REG_TARGET_ANCHOR_LOW:  regs.target_anchor_low  <= cfg.data;
        REG_TARGET_ANCHOR_HIGH: regs.target_anchor_high <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/aar_front.sv
`timescale 1ns / 1ps

module aar_front import aar_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    regs,
  aar_raw_if.sink raw,
  output logic    push_valid,
  input  logic    push_ready,
  output work_t   work
);
  `include "anchored_axis_remapper_macros.svh"

  logic   anchored;
  coord_t alo, ahi;
  coord_t lo, hi, tlo, thi;
  coord_t s;

  assign s          = raw.raw_coord;
  assign push_valid = raw.valid;
  assign raw.ready  = push_ready;

  always_comb begin
    anchored = |{regs.source_anchor_low, regs.source_anchor_high,
                 regs.target_anchor_low, regs.target_anchor_high};

    // Zero or out-of-range source anchors fall back to the source limits.
    if (regs.source_anchor_high == '0 || regs.source_anchor_high > regs.source_max) begin
      ahi = regs.source_max;
    end else begin
      ahi = regs.source_anchor_high;
    end
    if (regs.source_anchor_low == '0 || regs.source_anchor_low < regs.source_min) begin
      alo = regs.source_min;
    end else begin
      alo = regs.source_anchor_low;
    end

    if (!anchored) begin
      lo = regs.source_min;  hi = regs.source_max;
      tlo = regs.target_min; thi = regs.target_max;
    end else if (s < alo) begin
      lo = regs.source_min;  hi = alo;
      tlo = regs.target_min; thi = regs.target_anchor_low;
    end else if (s <= ahi) begin
      lo = alo;                     hi = ahi;
      tlo = regs.target_anchor_low; thi = regs.target_anchor_high;
    end else begin
      lo = ahi;                      hi = regs.source_max;
      tlo = regs.target_anchor_high; thi = regs.target_max;
    end

    // Upper clamp wins over lower clamp, so empty segments never divide.
    work.early = 1'b1;
    if (s >= hi) begin
      work.eval = thi;
    end else if (s <= lo) begin
      work.eval = tlo;
    end else begin
      work.early = 1'b0;
      work.eval  = tlo;
    end
    work.off   = s - lo;
    work.span  = hi - lo;
    work.dir   = thi < tlo;
    work.tspan = work.dir ? (tlo - thi) : (thi - tlo);
    work.tlo   = tlo;
  end

  `AAR_ASSERT(a_div_operands_sane, clk, rst,
    push_valid && !work.early |-> work.span != '0 && work.off < work.span)

endmodule

### rtl/aar_fifo.sv
`timescale 1ns / 1ps

module aar_fifo import aar_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);
  `include "anchored_axis_remapper_macros.svh"

  work_t                  store [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic                   push, pop;

  assign push_ready = count != QCOUNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AAR_ASSERT(a_fill_tracks_push, clk, rst,
    push && !pop |=> count == $past(count) + 1'b1)

endmodule

### rtl/aar_back.sv
`timescale 1ns / 1ps

module aar_back import aar_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  work_t         pop_data,
  aar_mapped_if.source  mapped
);
  `include "anchored_axis_remapper_macros.svh"

  typedef struct packed {
    logic                 early;
    coord_t               eval;
    coord_t               span;
    coord_t               tlo;
    logic                 dir;
    logic [PROD_BITS-1:0] acc;  // remainder above, numerator/quotient below
  } pipe_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic pipe_t div_step(pipe_t p);
    logic [COORD_BITS:0] part;
    logic [COORD_BITS:0] diff;
    logic                ge;
    pipe_t               r;
    part  = p.acc[PROD_BITS-1:COORD_BITS-1];
    diff  = part - {1'b0, p.span};
    ge    = part >= {1'b0, p.span};
    r     = p;
    r.acc = {(ge ? diff[COORD_BITS-1:0] : part[COORD_BITS-1:0]),
             p.acc[COORD_BITS-2:0], ge};
    return r;
  endfunction

  pipe_t               st [COORD_BITS+1];
  logic [COORD_BITS:0] vld;
  logic                en, pop;
  logic                out_valid;
  coord_t              out_coord;
  coord_t              quot;

  assign en        = !out_valid || mapped.ready;
  assign pop_ready = en;
  assign pop       = pop_valid && en;

  assign mapped.valid        = out_valid;
  assign mapped.mapped_coord = out_coord;

  assign quot = st[COORD_BITS].acc[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].early <= pop_data.early;
      st[0].eval  <= pop_data.eval;
      st[0].span  <= pop_data.span;
      st[0].tlo   <= pop_data.tlo;
      st[0].dir   <= pop_data.dir;
      st[0].acc   <= PROD_BITS'(pop_data.off) * PROD_BITS'(pop_data.tspan);
      for (int k = 0; k < COORD_BITS; k++) begin
        st[k+1] <= div_step(st[k]);
      end
      if (st[COORD_BITS].early) begin
        out_coord <= st[COORD_BITS].eval;
      end else if (st[COORD_BITS].dir) begin
        out_coord <= st[COORD_BITS].tlo - quot;
      end else begin
        out_coord <= st[COORD_BITS].tlo + quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[COORD_BITS-1:0], pop};
      out_valid <= vld[COORD_BITS];
    end
  end

  `AAR_ASSERT_STABLE(a_stall_freezes_pipe, clk, rst, out_valid && !mapped.ready, vld)
  `AAR_ASSERT(a_result_follows_last_stage, clk, rst,
    en && vld[COORD_BITS] |=> out_valid)

endmodule

### rtl/anchored_axis_remapper.sv
`timescale 1ns / 1ps
// Piecewise-linear axis remapper with an optional central anchor window.
// Channels: raw carries one raw_coord per transfer in; mapped carries one
// mapped_coord per transfer out; cfg writes one of eight range registers
// (index 0..7, higher indexes are dropped) and is always ready. Write cfg
// only while no coordinate is in flight.
// Throughput: one coordinate per cycle sustained while the receiver is ready.
// Path: a coordinate accepted on raw is written into the queue, then passes
// the multiplier register, the COORD_BITS stages of the one-bit-per-stage
// divider and the output register before it appears on mapped. The divider
// pipeline sets the latency.
// Reset (synchronous, rst high) loads the default full-range mapping,
// disables anchoring and empties the queue and pipeline.
// When the receiver stalls, the whole back pipeline holds; the two-entry
// queue keeps taking raw transfers until it fills, then raw.ready drops.
module anchored_axis_remapper import aar_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  aar_cfg_if.sink      cfg,
  aar_raw_if.sink      raw,
  aar_mapped_if.source mapped
);

  cfg_t  regs;
  work_t push_data, pop_data;
  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;

  // Hold the range registers; the user must write them only between bursts, the block does not enforce this.
  aar_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Classify each raw coordinate into its segment and clamp early.
  aar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .raw        (raw),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .work       (push_data)
  );

  // Decouple the classifier from the arithmetic so each side stalls alone.
  aar_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Multiply, divide and offset; advance only when the output can move.
  aar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .mapped    (mapped)
  );

endmodule
